// File: hw/rtl/bhtc_pkg.sv
`default_nettype none

package bhtc_pkg;

	localparam int NUM_WINDOWS = 3;
	localparam int WIN_IDX_W   = 2;
	localparam int MS_W        = 16;
	localparam int TIME_W      = 32;
	localparam int EN_W        = 3;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int REG_IDX_W   = 3;

	localparam logic [REG_IDX_W-1:0] REG_WIN_EN = 3'd6;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_CNT_W  = 3;
	localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 2);

	typedef struct packed {
		logic [NUM_WINDOWS-1:0][MS_W-1:0] win_min;
		logic [NUM_WINDOWS-1:0][MS_W-1:0] win_max;
		logic [EN_W-1:0]                  win_en;
	} cfg_t;

	typedef enum logic [1:0] {
		EV_ENTER    = 2'd0,
		EV_LEAVE    = 2'd1,
		EV_SELECTED = 2'd2
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t              kind;
		logic [WIN_IDX_W-1:0]  idx;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [1:0]        cnt;
		result_t [1:0]     res;
	} batch_t;

endpackage

`default_nettype wire

// File: hw/rtl/button_hold_time_classifier_unit.sv
`default_nettype none

// Button hold-time classifier. Each input transfer carries one button sample and the
// current millisecond time; a press starts a hold timer, and while the button is held
// the block reports leave and enter events as the hold time moves between the enabled
// windows (lowest index wins), then a selected event for the current window on release.
// A sample is taken every cycle while the four-entry result queue has at least two free
// entries, whatever the sample then produces; the output side moves one result per
// cycle while m_tready is high, and new samples are taken while earlier results still
// wait in the queue. The first result of a sample is offered once the sample has passed
// the input register and been written into the result queue. The window registers
// should be written only while no sample is in flight and the output queue is empty.
module button_hold_time_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bhtc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bhtc_pkg::DATA_W-1:0]   pwdata,
	output logic [bhtc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,   // button_level, now_ms[31:0], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // window_index[1:0], zero pad
	output logic [1:0]                    m_tuser,   // event_kind[1:0]
	output logic                          m_tlast
);
	import bhtc_pkg::*;

	cfg_t    cfg;
	batch_t  push;
	logic    room;
	result_t out_res;

	bhtc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bhtc_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.level    (s_tdata[0]),
		.now_ms   (s_tdata[TIME_W:1]),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	bhtc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = 8'(out_res.idx);
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/bhtc_cfg_regs.sv
`default_nettype none

module bhtc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bhtc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bhtc_pkg::DATA_W-1:0]   pwdata,
	output logic [bhtc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bhtc_pkg::cfg_t                cfg
);
	import bhtc_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [WIN_IDX_W-1:0] win_sel;
	logic                 win_ok;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign win_sel = reg_idx[REG_IDX_W-1:1];
	assign win_ok  = (reg_idx < REG_WIN_EN) && (int'(win_sel) < NUM_WINDOWS);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (reg_idx == REG_WIN_EN) begin
				cfg_q.win_en <= pwdata[EN_W-1:0];
			end else if (win_ok) begin
				if (reg_idx[0]) begin
					cfg_q.win_max[win_sel] <= pwdata[MS_W-1:0];
				end else begin
					cfg_q.win_min[win_sel] <= pwdata[MS_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_WIN_EN) begin
			prdata = DATA_W'(cfg_q.win_en);
		end else if (win_ok) begin
			if (reg_idx[0]) begin
				prdata = DATA_W'(cfg_q.win_max[win_sel]);
			end else begin
				prdata = DATA_W'(cfg_q.win_min[win_sel]);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bhtc_classify.sv
`default_nettype none

module bhtc_classify (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          level,
	input  logic [bhtc_pkg::TIME_W-1:0]   now_ms,
	input  bhtc_pkg::cfg_t                cfg,
	input  logic                          room,
	output bhtc_pkg::batch_t              push
);
	import bhtc_pkg::*;

	logic                  valid_s1;
	logic                  level_s1;
	logic [TIME_W-1:0]     now_s1;

	logic                  prev_q;
	logic [TIME_W-1:0]     start_q;
	logic                  active_q;
	logic [WIN_IDX_W-1:0]  aw_q;

	logic                  go;
	logic                  rise;
	logic                  fall;
	logic                  hold;
	logic [TIME_W-1:0]     held;
	logic [TIME_W-1:0]     t;
	logic                  found;
	logic [WIN_IDX_W-1:0]  idx;
	logic                  change;
	logic                  active_d;
	logic [WIN_IDX_W-1:0]  aw_d;
	batch_t                batch;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= level;
			now_s1   <= now_ms;
		end
	end

	assign rise = !prev_q && level_s1;
	assign fall = prev_q && !level_s1;
	assign hold = prev_q && level_s1;
	assign held = now_s1 - start_q;
	assign t    = rise ? '0 : held;

	// Scanning from the top down leaves the lowest matching window in place.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
			if (cfg.win_en[i] && (t >= TIME_W'(cfg.win_min[i]))
					&& (t <= TIME_W'(cfg.win_max[i]))) begin
				found = 1'b1;
				idx   = WIN_IDX_W'(i);
			end
		end
	end

	assign change = (found != active_q) || (found && (idx != aw_q));

	always_comb begin
		batch    = '0;
		active_d = active_q;
		aw_d     = aw_q;
		if (rise) begin
			active_d = found;
			aw_d     = found ? idx : '0;
			if (found) begin
				batch.cnt         = 2'd1;
				batch.res[0].kind = EV_ENTER;
				batch.res[0].idx  = idx;
			end
		end else if (fall) begin
			active_d = 1'b0;
			aw_d     = '0;
			if (active_q) begin
				batch.cnt         = 2'd1;
				batch.res[0].kind = EV_SELECTED;
				batch.res[0].idx  = aw_q;
			end
		end else if (hold && change) begin
			active_d = found;
			aw_d     = found ? idx : '0;
			if (active_q && found) begin
				batch.cnt         = 2'd2;
				batch.res[0].kind = EV_LEAVE;
				batch.res[0].idx  = aw_q;
				batch.res[1].kind = EV_ENTER;
				batch.res[1].idx  = idx;
			end else if (active_q) begin
				batch.cnt         = 2'd1;
				batch.res[0].kind = EV_LEAVE;
				batch.res[0].idx  = aw_q;
			end else begin
				batch.cnt         = 2'd1;
				batch.res[0].kind = EV_ENTER;
				batch.res[0].idx  = idx;
			end
		end
		if (batch.cnt == 2'd2) begin
			batch.res[1].last = 1'b1;
		end else begin
			batch.res[0].last = 1'b1;
		end
		if (!go) begin
			batch.cnt = 2'd0;
		end
	end

	assign push = batch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			start_q  <= '0;
			active_q <= 1'b0;
			aw_q     <= '0;
		end else if (go) begin
			prev_q   <= level_s1;
			active_q <= active_d;
			aw_q     <= aw_d;
			if (rise) begin
				start_q <= now_s1;
			end
		end
	end

	a_fall_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && fall |=> !active_q && (aw_q == '0))
		else $error("Release did not clear the current window.");

	a_enter_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) && (push.res[0].kind == EV_ENTER)
			|-> cfg.win_en[push.res[0].idx])
		else $error("Enter event names a disabled window.");

	a_no_selected_unless_active: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) && (push.res[0].kind == EV_SELECTED) |-> active_q && fall)
		else $error("Selected event without a current window.");

endmodule

`default_nettype wire

// File: hw/rtl/bhtc_result_fifo.sv
`default_nettype none

module bhtc_result_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bhtc_pkg::batch_t     push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bhtc_pkg::result_t    out_res
);
	import bhtc_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_q;
	logic [FIFO_PTR_W-1:0]   rd_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;
	logic                    pop;
	logic [FIFO_PTR_W-1:0]   wr_next;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= FIFO_ROOM_LIMIT);
	assign wr_next   = FIFO_PTR_W'(wr_q + 1'b1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.res[0];
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= FIFO_PTR_W'(wr_q + push.cnt);
			cnt_q <= FIFO_CNT_W'(cnt_q + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop));
			if (pop) begin
				rd_q <= FIFO_PTR_W'(rd_q + 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (int'(cnt_q) + int'(push.cnt) <= FIFO_DEPTH))
		else $error("Result queue overflow.");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0) && !pop |=> $stable(cnt_q))
		else $error("Result count changed without a transfer.");

endmodule

`default_nettype wire
